>>> hdl/sdf_pkg.sv
// Package: shared types and constants for the smooth damp follower.
`timescale 1ns / 1ps
package sdf_pkg;
  localparam int unsigned QW = 32;
  localparam int unsigned RW = 31;
  localparam logic [RW-1:0] T_FLOOR = 31'd7;
  localparam logic signed [QW-1:0] C_048 = 32'sd31457;
  localparam logic signed [QW-1:0] C_0235 = 32'sd15401;
  localparam logic signed [QW-1:0] Q_ONE = 32'sd65536;
  localparam logic signed [QW-1:0] SMAX = 32'sh7FFFFFFF;
  localparam logic signed [QW-1:0] SMIN = 32'sh80000000;

  localparam logic [1:0] REG_SMOOTH = 2'd0;
  localparam logic [1:0] REG_SPEED = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_DIV
  } op_e;

  typedef enum logic [4:0] {
    R_W, R_X, R_SQ, R_CUBE, R_DEN, R_DECAY, R_D, R_M, R_G, R_S, R_NV, R_N,
    R_TMP, R_DT, R_T, R_SPD, R_CUR, R_TGT, R_V, R_C048, R_C0235, R_ONE
  } reg_e;

  typedef struct packed {
    logic start;
    op_e  op;
    reg_e a;
    reg_e b;
    reg_e dst;
    logic clamp;
    logic load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [65:0] x);
    if (x > 66'(SMAX)) return SMAX;
    if (x < 66'(SMIN)) return SMIN;
    return x[QW-1:0];
  endfunction
endpackage

>>> hdl/smooth_damp_follower.sv
// Top level: smooth damp follower with configuration registers.
// Each item runs two serial divisions, eleven multiplies, nine adds and subtracts
// and one clamp step, in order, on one shared datapath; the result is registered.
// The next item is taken only after the result leaves; items do not overlap.
// Reset: velocity clears to zero, registers take their reset values.
`timescale 1ns / 1ps
module smooth_damp_follower (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [sdf_pkg::RW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [31:0] current_value_i,
  input  logic signed [31:0] target_value_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [31:0] next_value_o,
  output logic signed [31:0] velocity_out_o
);
  logic [sdf_pkg::RW-1:0] smooth_q, speed_q, step_q;
  logic signed [31:0] cur_q, tgt_q;
  sdf_pkg::cmd_t cmd;
  sdf_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 31'd65536;
      speed_q <= 31'h7FFFFFFF;
      step_q <= 31'd1092;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdf_pkg::REG_SMOOTH: smooth_q <= cfg_data_i;
        sdf_pkg::REG_SPEED:  speed_q <= cfg_data_i;
        sdf_pkg::REG_STEP:   step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cur_q <= current_value_i;
      tgt_q <= target_value_i;
    end
  end

  sdf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  sdf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .smooth_time_i(smooth_q), .max_speed_i(speed_q), .time_step_i(step_q),
    .cur_i(cur_q), .tgt_i(tgt_q), .next_o(next_value_o), .vel_o(velocity_out_o)
  );
endmodule

>>> hdl/sdf_datapath.sv
// Datapath: register file, shared multiplier, serial divider and result logic.
`timescale 1ns / 1ps
module sdf_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  sdf_pkg::cmd_t cmd_i,
  output sdf_pkg::sts_t sts_o,
  input  logic [sdf_pkg::RW-1:0] smooth_time_i,
  input  logic [sdf_pkg::RW-1:0] max_speed_i,
  input  logic [sdf_pkg::RW-1:0] time_step_i,
  input  logic signed [sdf_pkg::QW-1:0] cur_i,
  input  logic signed [sdf_pkg::QW-1:0] tgt_i,
  output logic signed [sdf_pkg::QW-1:0] next_o,
  output logic signed [sdf_pkg::QW-1:0] vel_o
);
  logic signed [sdf_pkg::QW-1:0] rf_q [22];
  logic signed [sdf_pkg::QW-1:0] vel_q;
  logic signed [sdf_pkg::QW-1:0] a, b, res;
  logic signed [65:0] prod, sum;
  logic [33:0] num_q, quo_q;
  logic [33:0] den_q;
  logic [33:0] rem_q;
  logic [34:0] rem_sh;
  logic [5:0] cnt_q;
  logic div_q, mul_q;
  logic signed [65:0] prod_q;
  sdf_pkg::reg_e dst_q;
  logic signed [sdf_pkg::QW-1:0] m, d, dc, nv_n;
  logic up, past;

  always_comb begin
    case (cmd_i.a)
      sdf_pkg::R_DT:    a = {1'b0, time_step_i};
      sdf_pkg::R_T:     a = (smooth_time_i < sdf_pkg::T_FLOOR) ?
                            {1'b0, sdf_pkg::T_FLOOR} : {1'b0, smooth_time_i};
      sdf_pkg::R_SPD:   a = {1'b0, max_speed_i};
      sdf_pkg::R_CUR:   a = cur_i;
      sdf_pkg::R_TGT:   a = tgt_i;
      sdf_pkg::R_V:     a = vel_q;
      sdf_pkg::R_C048:  a = sdf_pkg::C_048;
      sdf_pkg::R_C0235: a = sdf_pkg::C_0235;
      sdf_pkg::R_ONE:   a = sdf_pkg::Q_ONE;
      default:          a = rf_q[cmd_i.a];
    endcase
    case (cmd_i.b)
      sdf_pkg::R_DT:    b = {1'b0, time_step_i};
      sdf_pkg::R_T:     b = (smooth_time_i < sdf_pkg::T_FLOOR) ?
                            {1'b0, sdf_pkg::T_FLOOR} : {1'b0, smooth_time_i};
      sdf_pkg::R_SPD:   b = {1'b0, max_speed_i};
      sdf_pkg::R_CUR:   b = cur_i;
      sdf_pkg::R_TGT:   b = tgt_i;
      sdf_pkg::R_V:     b = vel_q;
      sdf_pkg::R_C048:  b = sdf_pkg::C_048;
      sdf_pkg::R_C0235: b = sdf_pkg::C_0235;
      sdf_pkg::R_ONE:   b = sdf_pkg::Q_ONE;
      default:          b = rf_q[cmd_i.b];
    endcase
    prod = 66'(a) * 66'(b);
    case (cmd_i.op)
      sdf_pkg::OP_SUB: sum = 66'(a) - 66'(b);
      default:         sum = 66'(a) + 66'(b);
    endcase
    res = sdf_pkg::sat32(sum);
  end

  assign rem_sh = {rem_q, num_q[33]};
  assign m = rf_q[sdf_pkg::R_M];
  assign d = rf_q[sdf_pkg::R_D];
  always_comb begin
    dc = d;
    if (m != sdf_pkg::SMAX) begin
      if (d > m) dc = m;
      if (d < -m) dc = -m;
    end
  end
  assign up = tgt_i > cur_i;
  assign past = rf_q[sdf_pkg::R_N] > tgt_i;
  assign nv_n = (up == past) ? '0 : rf_q[sdf_pkg::R_NV];
  assign sts_o.busy = div_q | mul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      div_q <= 1'b0;
      mul_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.start) begin
        dst_q <= cmd_i.dst;
        case (cmd_i.op)
          sdf_pkg::OP_MUL: begin
            prod_q <= prod;
            mul_q <= 1'b1;
          end
          sdf_pkg::OP_DIV: begin
            num_q <= (cmd_i.a == sdf_pkg::R_ONE) ? 34'h1_0000_0000 : 34'h2_0000_0000;
            den_q <= {2'b00, b};
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= 6'd34;
            div_q <= 1'b1;
          end
          default: rf_q[cmd_i.dst] <= res;
        endcase
      end
      if (mul_q) begin
        rf_q[dst_q] <= sdf_pkg::sat32(prod_q / 66'sd65536);
        mul_q <= 1'b0;
      end
      if (div_q) begin
        num_q <= {num_q[32:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= 34'(rem_sh - {1'b0, den_q});
          quo_q <= {quo_q[32:0], 1'b1};
        end else begin
          rem_q <= rem_sh[33:0];
          quo_q <= {quo_q[32:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) div_q <= 1'b0;
      end
      if (cmd_i.load) rf_q[dst_q] <= sdf_pkg::sat32({32'b0, quo_q});
      if (cmd_i.clamp) rf_q[sdf_pkg::R_D] <= dc;
      if (cmd_i.finish) begin
        vel_q <= nv_n;
        next_o <= (up == past) ? tgt_i : rf_q[sdf_pkg::R_N];
        vel_o <= nv_n;
      end
    end
  end
endmodule

>>> hdl/sdf_ctrl.sv
// Controller: sequences the operations of one item over the shared datapath.
`timescale 1ns / 1ps
module sdf_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sdf_pkg::sts_t sts_i,
  output sdf_pkg::cmd_t cmd_o
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_OUT} state_e;
  state_e state_q;
  logic [4:0] pc_q;
  sdf_pkg::cmd_t step;
  logic is_div;

  always_comb begin
    step = '0;
    step.op = sdf_pkg::OP_MUL;
    step.a = sdf_pkg::R_W;
    step.b = sdf_pkg::R_W;
    step.dst = sdf_pkg::R_W;
    case (pc_q)
      5'd0:  begin step.op = sdf_pkg::OP_DIV; step.a = sdf_pkg::R_T;
                   step.b = sdf_pkg::R_T; step.dst = sdf_pkg::R_W; end
      5'd1:  begin step.a = sdf_pkg::R_W; step.b = sdf_pkg::R_DT; step.dst = sdf_pkg::R_X; end
      5'd2:  begin step.a = sdf_pkg::R_X; step.b = sdf_pkg::R_X; step.dst = sdf_pkg::R_SQ; end
      5'd3:  begin step.a = sdf_pkg::R_SQ; step.b = sdf_pkg::R_X; step.dst = sdf_pkg::R_CUBE; end
      5'd4:  begin step.op = sdf_pkg::OP_ADD; step.a = sdf_pkg::R_ONE;
                   step.b = sdf_pkg::R_X; step.dst = sdf_pkg::R_DEN; end
      5'd5:  begin step.a = sdf_pkg::R_C048; step.b = sdf_pkg::R_SQ; step.dst = sdf_pkg::R_TMP; end
      5'd6:  begin step.op = sdf_pkg::OP_ADD; step.a = sdf_pkg::R_DEN;
                   step.b = sdf_pkg::R_TMP; step.dst = sdf_pkg::R_DEN; end
      5'd7:  begin step.a = sdf_pkg::R_C0235; step.b = sdf_pkg::R_CUBE; step.dst = sdf_pkg::R_TMP; end
      5'd8:  begin step.op = sdf_pkg::OP_ADD; step.a = sdf_pkg::R_DEN;
                   step.b = sdf_pkg::R_TMP; step.dst = sdf_pkg::R_DEN; end
      5'd9:  begin step.op = sdf_pkg::OP_DIV; step.a = sdf_pkg::R_ONE;
                   step.b = sdf_pkg::R_DEN; step.dst = sdf_pkg::R_DECAY; end
      5'd10: begin step.op = sdf_pkg::OP_SUB; step.a = sdf_pkg::R_CUR;
                   step.b = sdf_pkg::R_TGT; step.dst = sdf_pkg::R_D; end
      5'd11: begin step.a = sdf_pkg::R_SPD; step.b = sdf_pkg::R_T; step.dst = sdf_pkg::R_M; end
      5'd12: begin step.op = sdf_pkg::OP_ADD; step.a = sdf_pkg::R_ONE; step.b = sdf_pkg::R_ONE;
                   step.dst = sdf_pkg::R_TMP; step.clamp = 1'b1; step.start = 1'b0; end
      5'd13: begin step.op = sdf_pkg::OP_SUB; step.a = sdf_pkg::R_CUR;
                   step.b = sdf_pkg::R_D; step.dst = sdf_pkg::R_G; end
      5'd14: begin step.a = sdf_pkg::R_W; step.b = sdf_pkg::R_D; step.dst = sdf_pkg::R_TMP; end
      5'd15: begin step.op = sdf_pkg::OP_ADD; step.a = sdf_pkg::R_V;
                   step.b = sdf_pkg::R_TMP; step.dst = sdf_pkg::R_TMP; end
      5'd16: begin step.a = sdf_pkg::R_TMP; step.b = sdf_pkg::R_DT; step.dst = sdf_pkg::R_S; end
      5'd17: begin step.a = sdf_pkg::R_W; step.b = sdf_pkg::R_S; step.dst = sdf_pkg::R_TMP; end
      5'd18: begin step.op = sdf_pkg::OP_SUB; step.a = sdf_pkg::R_V;
                   step.b = sdf_pkg::R_TMP; step.dst = sdf_pkg::R_TMP; end
      5'd19: begin step.a = sdf_pkg::R_TMP; step.b = sdf_pkg::R_DECAY; step.dst = sdf_pkg::R_NV; end
      5'd20: begin step.op = sdf_pkg::OP_ADD; step.a = sdf_pkg::R_D;
                   step.b = sdf_pkg::R_S; step.dst = sdf_pkg::R_TMP; end
      5'd21: begin step.a = sdf_pkg::R_TMP; step.b = sdf_pkg::R_DECAY; step.dst = sdf_pkg::R_TMP; end
      5'd22: begin step.op = sdf_pkg::OP_ADD; step.a = sdf_pkg::R_G;
                   step.b = sdf_pkg::R_TMP; step.dst = sdf_pkg::R_N; end
      default: step.finish = 1'b1;
    endcase
    if (pc_q != 5'd12 && pc_q <= 5'd22) step.start = 1'b1;
    is_div = (step.op == sdf_pkg::OP_DIV);
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.op = step.op;
    cmd_o.a = step.a;
    cmd_o.b = step.b;
    cmd_o.dst = step.dst;
    if (state_q == S_RUN) begin
      cmd_o.start = step.start;
      cmd_o.clamp = step.clamp;
      cmd_o.finish = step.finish;
    end
    if (state_q == S_WAIT && !sts_i.busy) cmd_o.load = is_div;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          state_q <= S_RUN;
          pc_q <= '0;
        end
        S_RUN: begin
          if (step.finish) begin
            state_q <= S_OUT;
            out_valid_o <= 1'b1;
          end else if (step.start) begin
            state_q <= S_WAIT;
          end else begin
            pc_q <= pc_q + 5'd1;
          end
        end
        S_WAIT: begin
          if (!sts_i.busy) begin
            state_q <= S_RUN;
            pc_q <= pc_q + 5'd1;
          end
        end
        S_OUT: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !out_valid_o) else $error("result shown while idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item taken while result waits");
endmodule

>>> sim/smooth_damp_follower_test.sv
// Testbench: drives random and directed items into the smooth damp follower and checks results.
`timescale 1ns / 1ps
module smooth_damp_follower_test;

  typedef struct {
    logic signed [31:0] cur;
    logic signed [31:0] tgt;
  } follow_item_t;

  typedef struct {
    logic signed [31:0] next;
    logic signed [31:0] vel;
  } follow_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = sdf_pkg::REG_SMOOTH;
  logic [sdf_pkg::RW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] current_value_i = '0;
  logic signed [31:0] target_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] next_value_o;
  logic signed [31:0] velocity_out_o;

  follow_item_t pending_items[$];
  follow_result_t expected_results[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit press_req = 1'b0;

  longint smooth_t = 65536;
  longint speed_max = 64'h7FFFFFFF;
  longint step_dt = 1092;
  longint vel_state = 0;

  smooth_damp_follower dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint clip(longint x);
    if (x > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (x < -64'sh80000000) return -64'sh80000000;
    return x;
  endfunction

  function automatic longint qm(longint a, longint b);
    return clip((a * b) / 65536);
  endfunction

  function automatic follow_result_t damp_step(follow_item_t it);
    longint cur, tgt, t, w, x, sq, cube, den, decay, d, m, g, s, nv, n;
    follow_result_t r;
    cur = longint'(it.cur);
    tgt = longint'(it.tgt);
    t = (smooth_t < 7) ? 7 : smooth_t;
    w = clip((64'sd1 << 33) / t);
    x = qm(w, step_dt);
    sq = qm(x, x);
    cube = qm(sq, x);
    den = clip(65536 + x);
    den = clip(den + qm(31457, sq));
    den = clip(den + qm(15401, cube));
    decay = (64'sd1 << 32) / den;
    d = clip(cur - tgt);
    m = qm(speed_max, t);
    if (m < 64'sh7FFFFFFF) begin
      if (d > m) d = m;
      if (d < -m) d = -m;
    end
    g = clip(cur - d);
    s = qm(clip(vel_state + qm(w, d)), step_dt);
    nv = qm(clip(vel_state - qm(w, s)), decay);
    n = clip(g + qm(clip(d + s), decay));
    if ((tgt > cur) == (n > tgt)) begin
      n = tgt;
      nv = 0;
    end
    vel_state = nv;
    r.next = n[31:0];
    r.vel = nv[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver
  int gap = 0;
  always @(posedge clk_i) begin
    follow_item_t it;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        it.cur = current_value_i;
        it.tgt = target_value_i;
        expected_results.push_back(damp_step(it));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          current_value_i <= it.cur;
          target_value_i <= it.tgt;
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int stall = 0;
  bit press_done = 1'b0;
  always @(posedge clk_i) begin
    follow_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result %0d %0d at %0t", next_value_o, velocity_out_o, $realtime);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (next_value_o !== want.next) report_mismatch("next_value", next_value_o, want.next);
          if (velocity_out_o !== want.vel) report_mismatch("velocity_out", velocity_out_o, want.vel);
        end
      end
      if (press_req && !press_done) begin
        press_done = 1'b1;
        stall = 3000;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 7) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [sdf_pkg::RW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      sdf_pkg::REG_SMOOTH: smooth_t = longint'(val);
      sdf_pkg::REG_SPEED: speed_max = longint'(val);
      default: step_dt = longint'(val);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [sdf_pkg::RW-1:0] t, logic [sdf_pkg::RW-1:0] sp,
                           logic [sdf_pkg::RW-1:0] dt);
    wait_idle();
    set_reg(sdf_pkg::REG_SMOOTH, t);
    set_reg(sdf_pkg::REG_SPEED, sp);
    set_reg(sdf_pkg::REG_STEP, dt);
  endtask

  task automatic add_item(logic signed [31:0] c, logic signed [31:0] t);
    follow_item_t it;
    it.cur = c;
    it.tgt = t;
    pending_items.push_back(it);
  endtask

  task automatic add_random(int n);
    logic signed [31:0] c;
    for (int i = 0; i < n; i++) begin
      c = $urandom;
      case ($urandom_range(0, 3))
        0: add_item(c, $urandom);
        1: add_item(c, c + $signed($urandom_range(0, 4000)) - 2000);
        2: add_item(c, c);
        default: add_item($signed($urandom_range(0, 400000)) - 200000,
                          $signed($urandom_range(0, 400000)) - 200000);
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_item(sdf_pkg::SMAX, sdf_pkg::SMIN);
    add_item(sdf_pkg::SMIN, sdf_pkg::SMAX);
    add_item(0, 0);
    add_item(sdf_pkg::SMIN, sdf_pkg::SMIN);
    add_item(sdf_pkg::SMAX, sdf_pkg::SMAX);
    add_item(0, sdf_pkg::Q_ONE);
    add_item(sdf_pkg::Q_ONE, 0);
    add_item(100, 101);
    add_item(-5, -5);
    configure(0, 0, 1);
    add_item(sdf_pkg::SMIN, sdf_pkg::SMAX);
    add_item(sdf_pkg::Q_ONE, -sdf_pkg::Q_ONE);
    add_item(3, 3);
    configure(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_item(sdf_pkg::SMAX, sdf_pkg::SMIN);
    add_item(sdf_pkg::SMIN, sdf_pkg::SMAX);
    add_item(7, 9);
    configure(65536, 31'h7FFFFFFF, 0);
    add_item(sdf_pkg::SMIN, sdf_pkg::SMAX);
    add_item(sdf_pkg::Q_ONE, 0);
    add_item(sdf_pkg::SMAX, sdf_pkg::SMIN);
    configure(6, 31'h7FFFFFFF, 1092);
    add_item(sdf_pkg::SMAX, sdf_pkg::SMIN);
    add_item(0, sdf_pkg::Q_ONE);
    configure(65536, 31'h7FFFFFFF, 1092);
    add_random(130);
    press_req = 1'b1;
    configure(32768, 655360, 3000);
    add_random(130);
    configure(0, 0, 1);
    add_random(60);
    for (int p = 0; p < 3; p++) begin
      configure(31'($urandom), 31'($urandom), 31'($urandom));
      add_random(50);
      configure(31'($urandom_range(0, 200000)), 31'($urandom_range(0, 2000000)),
                31'($urandom_range(1, 20000)));
      add_random(50);
    end
    quiet = 1'b1;
    configure(65536, 31'h7FFFFFFF, 1092);
    add_random(50);
    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
